@@ sv/saft_pkg.sv @@
// ----------------------------------------------------------------------------
// saft_pkg
// Shared constants and types of the sorted address fixup table.
// ----------------------------------------------------------------------------
package saft_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 64;
	localparam int FIX_W       = 64;
	localparam int ENT_W       = KEY_W + FIX_W;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic [FIX_W-1:0] fixup_out;
		logic             hit;
		logic             full_res;
	} res_t;

endpackage

@@ sv/saft_if.sv @@
// ----------------------------------------------------------------------------
// saft_in_if / saft_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface saft_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] key_addr;
	logic [63:0] fixup_in;

	modport source (output valid, kind, key_addr, fixup_in, input ready);
	modport sink   (input valid, kind, key_addr, fixup_in, output ready);
endinterface

interface saft_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] fixup_out;
	logic        hit;
	logic        full_res;

	modport source (output valid, fixup_out, hit, full_res, input ready);
	modport sink   (input valid, fixup_out, hit, full_res, output ready);
endinterface

@@ sv/sorted_address_fixup_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_address_fixup_table_top
// Sorted table of (instruction address, fixup address) pairs with lookup.
// ----------------------------------------------------------------------------
// Holds up to TABLE_DEPTH pairs in one registered-read RAM, kept in ascending
// unsigned key order. Each request transaction gives exactly one result
// transaction. A lookup bisects the stored entries, each probe being a RAM
// read followed by a compare. An insert runs the same bisection for its
// position, then shifts every entry above it up by one at one entry per
// cycle through the RAM's read and write ports, and writes the new pair. An
// insert into a full table returns full_res at once. One request is worked
// on at a time; a finished result sits in an output register so the next
// request can be taken while it waits.
module sorted_address_fixup_table_top (
	input  logic       clk,
	input  logic       arst_n,
	saft_in_if.sink    req,
	saft_out_if.source rsp
);
	import saft_pkg::*;

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	logic              out_valid_q;
	res_t              out_q;

	saft_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	saft_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.fixup_out = out_q.fixup_out;
	assign rsp.hit       = out_q.hit;
	assign rsp.full_res  = out_q.full_res;

endmodule

@@ sv/saft_ram.sv @@
// ----------------------------------------------------------------------------
// saft_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module saft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/saft_engine.sv @@
// ----------------------------------------------------------------------------
// saft_engine
// Bisection search and insertion shift over the entry memory.
// ----------------------------------------------------------------------------
module saft_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	saft_in_if.sink                   req,
	output logic                      res_valid,
	input  logic                      res_ready,
	output saft_pkg::res_t            res,
	output logic                      ram_we,
	output logic [saft_pkg::ADDR_W-1:0] ram_waddr,
	output logic [saft_pkg::ENT_W-1:0]  ram_wdata,
	output logic [saft_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [saft_pkg::ENT_W-1:0]  ram_rdata
);
	import saft_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_CMP, S_SHIFT, S_PLACE, S_RESP
	} state_t;

	state_t            state_q;
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [FIX_W-1:0]  fix_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;     // exclusive upper bound
	logic [CNT_W-1:0]  mid_q;
	logic [CNT_W-1:0]  left_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] pend_addr_s1;
	res_t              res_q;

	logic [CNT_W-1:0]  mid;
	logic [KEY_W-1:0]  rd_key;
	logic [FIX_W-1:0]  rd_fix;

	// mid = lo + (hi_incl - lo) / 2, only used while lo < hi
	assign mid    = lo_q + ((hi_q - lo_q - CNT_W'(1)) >> 1);
	assign rd_key = ram_rdata[ENT_W-1:FIX_W];
	assign rd_fix = ram_rdata[FIX_W-1:0];

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_comb begin
		ram_raddr = (state_q == S_SHIFT) ? rd_addr_q : mid[ADDR_W-1:0];
		if (state_q == S_PLACE) begin
			ram_we    = 1'b1;
			ram_waddr = lo_q[ADDR_W-1:0];
			ram_wdata = {key_q, fix_q};
		end else begin
			// shifted entry moves up by one
			ram_we    = pend_s1;
			ram_waddr = pend_addr_s1;
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q          <= req.kind;
						key_q           <= req.key_addr;
						fix_q           <= req.fixup_in;
						lo_q            <= '0;
						hi_q            <= count_q;
						res_q.fixup_out <= '0;
						res_q.hit       <= 1'b0;
						if (req.kind == KIND_INSERT &&
						    count_q == CNT_W'(TABLE_DEPTH)) begin
							res_q.full_res <= 1'b1;
							state_q        <= S_RESP;
						end else begin
							res_q.full_res <= 1'b0;
							state_q        <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else if (kind_q == KIND_LOOKUP) begin
						state_q <= S_RESP;
					end else begin
						left_q    <= count_q - lo_q;
						rd_addr_q <= ADDR_W'(count_q - CNT_W'(1));
						state_q   <= S_SHIFT;
					end
				end
				S_CMP: begin
					if (kind_q == KIND_LOOKUP && rd_key == key_q) begin
						res_q.fixup_out <= rd_fix;
						res_q.hit       <= 1'b1;
						state_q         <= S_RESP;
					end else begin
						if (rd_key < key_q) begin
							lo_q <= mid_q + CNT_W'(1);
						end else begin
							hi_q <= mid_q;
						end
						state_q <= S_ISSUE;
					end
				end
				S_SHIFT: begin
					pend_s1 <= (left_q != '0);
					if (left_q != '0) begin
						pend_addr_s1 <= rd_addr_q + ADDR_W'(1);
						rd_addr_q    <= rd_addr_q - ADDR_W'(1);
						left_q       <= left_q - CNT_W'(1);
					end else if (!pend_s1) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
